[rtl/rgb_point_ops_row_mirror_defines.svh]
// assertion macros for the rtl files, included by rpo_mirror.sv
`ifndef RGB_POINT_OPS_ROW_MIRROR_DEFINES_SVH
`define RGB_POINT_OPS_ROW_MIRROR_DEFINES_SVH

`ifndef SYNTH
// condition holds in the same cycle
`define RPO_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// condition holds in the next cycle
`define RPO_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define RPO_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define RPO_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

[rtl/rpo_pkg.sv]
`timescale 1ns / 1ps

package rpo_pkg;

  // sizing
  localparam int MAX_WIDTH      = 2048;
  localparam int NUM_SLOTS      = 8;
  localparam int COMPONENT_BITS = 16;
  localparam int FIELD_W        = 16;
  localparam int PROG_W         = 32;
  localparam int CMAX_W         = 16;
  localparam int RWIDTH_W       = 11;
  localparam int CFG_INDEX_W    = 2;
  localparam int IDX_W          = $clog2(MAX_WIDTH);
  localparam int COL_W          = $clog2(MAX_WIDTH + 1);
  localparam int ADDR_W         = $clog2(2 * MAX_WIDTH);
  localparam int STORE_W        = 3 * COMPONENT_BITS + 1;

  // divide by three through a reciprocal, exact for any sum of three components
  localparam int SUM_W       = COMPONENT_BITS + 2;
  localparam int GRAY_SHIFT  = COMPONENT_BITS + 3;
  localparam int RECIP_W     = GRAY_SHIFT - 1;
  localparam int PROD_W      = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((1 << GRAY_SHIFT) + 2) / 3);

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_OP_PROGRAM = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COLOR_MAX  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ROW_WIDTH  = 2'd2;

  // register reset values
  localparam logic [PROG_W-1:0]   OP_PROGRAM_RESET = '0;
  localparam logic [CMAX_W-1:0]   COLOR_MAX_RESET  = 16'd255;
  localparam logic [RWIDTH_W-1:0] ROW_WIDTH_RESET  = 11'd640;

  // item kinds
  localparam logic ITEM_PIXEL = 1'b0;
  localparam logic ITEM_DRAIN = 1'b1;

  // slot codes
  typedef enum logic [3:0] {
    OP_NONE    = 4'd0,
    OP_NEG_R   = 4'd1,
    OP_NEG_G   = 4'd2,
    OP_NEG_B   = 4'd3,
    OP_FLAT_R  = 4'd4,
    OP_FLAT_G  = 4'd5,
    OP_FLAT_B  = 4'd6,
    OP_GRAY    = 4'd7,
    OP_FLIP    = 4'd8
  } slot_op_t;

  typedef logic [COMPONENT_BITS-1:0] comp_t;

  typedef struct packed {
    comp_t r;
    comp_t g;
    comp_t b;
  } pix_t;

  typedef struct packed {
    logic drain;
    pix_t pix;
    logic over;
  } stage_t;

  typedef struct packed {
    logic [PROG_W-1:0]   op_program;
    logic [CMAX_W-1:0]   color_max;
    logic [RWIDTH_W-1:0] row_width;
  } cfg_t;

  // slot code, slots past the register read as none
  function automatic logic [3:0] slot_code(logic [PROG_W-1:0] prog, int idx);
    logic [3:0] c;
    c = OP_NONE;
    if (idx * 4 + 4 <= PROG_W) c = prog[idx*4 +: 4];
    return c;
  endfunction

  // absolute distance to the maximum
  function automatic comp_t negate(comp_t v, comp_t m);
    return (v >= m) ? comp_t'(v - m) : comp_t'(m - v);
  endfunction

  // floor of sum / 3
  function automatic comp_t gray(pix_t p);
    logic [SUM_W-1:0]  sum;
    logic [PROD_W-1:0] prod;
    sum  = SUM_W'(p.r) + SUM_W'(p.g) + SUM_W'(p.b);
    prod = PROD_W'(sum) * PROD_W'(RECIP);
    return prod[GRAY_SHIFT +: COMPONENT_BITS];
  endfunction

  // one slot applied to one stage
  function automatic stage_t apply_slot(logic [3:0] code, stage_t s, comp_t m);
    stage_t o;
    comp_t  q;
    o = s;
    q = gray(s.pix);
    if (!s.over) begin
      case (code)
        OP_NEG_R:  o.pix.r = negate(s.pix.r, m);
        OP_NEG_G:  o.pix.g = negate(s.pix.g, m);
        OP_NEG_B:  o.pix.b = negate(s.pix.b, m);
        OP_FLAT_R: o.pix.r = '0;
        OP_FLAT_G: o.pix.g = '0;
        OP_FLAT_B: o.pix.b = '0;
        OP_GRAY: begin
          o.pix.r = q;
          o.pix.g = q;
          o.pix.b = q;
        end
        default: ;
      endcase
    end
    return o;
  endfunction

endpackage

[rtl/rpo_pixel_if.sv]
`timescale 1ns / 1ps

// pixel request channel
interface rpo_pixel_if;
  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic [rpo_pkg::FIELD_W-1:0] red;
  logic [rpo_pkg::FIELD_W-1:0] green;
  logic [rpo_pkg::FIELD_W-1:0] blue;

  modport source (output valid, operation, red, green, blue, input ready);
  modport sink   (input valid, operation, red, green, blue, output ready);
endinterface

[rtl/rpo_result_if.sv]
`timescale 1ns / 1ps

// result request channel
interface rpo_result_if;
  logic                       valid;
  logic                       ready;
  logic [rpo_pkg::FIELD_W-1:0] out_red;
  logic [rpo_pkg::FIELD_W-1:0] out_green;
  logic [rpo_pkg::FIELD_W-1:0] out_blue;
  logic                       row_end;
  logic                       over_range;

  modport source (output valid, out_red, out_green, out_blue, row_end, over_range,
                  input ready);
  modport sink   (input valid, out_red, out_green, out_blue, row_end, over_range,
                  output ready);
endinterface

[rtl/rpo_reg_if.sv]
`timescale 1ns / 1ps

// register write channel
interface rpo_reg_if;
  logic                           valid;
  logic                           ready;
  logic [rpo_pkg::CFG_INDEX_W-1:0] index;
  logic [rpo_pkg::PROG_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/rpo_ram.sv]
`timescale 1ns / 1ps

// simple dual port ram, registered read
module rpo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

[rtl/rpo_slot_pipe.sv]
`timescale 1ns / 1ps

// one register stage per program slot
module rpo_slot_pipe (
  input  logic               clk,
  input  logic               rst,
  rpo_pixel_if.sink          pixel,
  input  rpo_pkg::cfg_t      cfg,
  output logic               tail_valid,
  output rpo_pkg::stage_t    tail,
  input  logic               tail_ready
);

  localparam int N = rpo_pkg::NUM_SLOTS;
  localparam int C = rpo_pkg::COMPONENT_BITS;

  logic [N-1:0]    v;
  rpo_pkg::stage_t st [N];
  logic [N:0]      acc;
  rpo_pkg::comp_t  cmax;
  rpo_pkg::stage_t head;

  assign cmax = cfg.color_max[C-1:0];

  // a stage takes new data when empty or when it moves on
  always_comb begin
    acc[N] = tail_ready;
    for (int i = N - 1; i >= 0; i--) acc[i] = !v[i] || acc[i+1];
  end

  assign pixel.ready = acc[0];

  // incoming pixel with its range flag
  always_comb begin
    head.drain = pixel.operation == rpo_pkg::ITEM_DRAIN;
    head.pix.r = pixel.red[C-1:0];
    head.pix.g = pixel.green[C-1:0];
    head.pix.b = pixel.blue[C-1:0];
    head.over  = (head.pix.r > cmax) || (head.pix.g > cmax) || (head.pix.b > cmax);
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (acc[0]) v[0] <= pixel.valid;
      for (int i = 1; i < N; i++) begin
        if (acc[i]) v[i] <= v[i-1];
      end
    end
  end

  // stage data, slot i-1 applied on the way into stage i
  always_ff @(posedge clk) begin
    if (acc[0]) st[0] <= head;
    for (int i = 1; i < N; i++) begin
      if (acc[i]) st[i] <= rpo_pkg::apply_slot(rpo_pkg::slot_code(cfg.op_program, i - 1),
                                               st[i-1], cmax);
    end
  end

  // last slot applied on the way out
  assign tail_valid = v[N-1];
  assign tail = rpo_pkg::apply_slot(rpo_pkg::slot_code(cfg.op_program, N - 1),
                                    st[N-1], cmax);

endmodule

[rtl/rpo_mirror.sv]
`timescale 1ns / 1ps
`include "rgb_point_ops_row_mirror_defines.svh"

// row mirror through a two-bank line store, plus the result register
module rpo_mirror (
  input  logic            clk,
  input  logic            rst,
  input  rpo_pkg::cfg_t   cfg,
  input  logic            tail_valid,
  input  rpo_pkg::stage_t tail,
  output logic            tail_ready,
  rpo_result_if.source    result
);

  localparam int IDX_W   = rpo_pkg::IDX_W;
  localparam int COL_W   = rpo_pkg::COL_W;
  localparam int ADDR_W  = rpo_pkg::ADDR_W;
  localparam int STORE_W = rpo_pkg::STORE_W;
  localparam int C       = rpo_pkg::COMPONENT_BITS;
  localparam int F       = rpo_pkg::FIELD_W;

  // mirror state
  logic [IDX_W-1:0] write_column, write_column_next;
  logic             write_bank, write_bank_next;
  logic             stored_ready, stored_ready_next;
  logic [COL_W-1:0] read_column, read_column_next;

  // result register
  logic         r_valid;
  logic         r_from_ram;
  logic         r_last;
  logic         r_over;
  rpo_pkg::pix_t r_pix;

  logic               res_valid, res_from_ram, res_last;
  logic               fire, acc_r, odd;
  logic [COL_W-1:0]   w_eff, wm1, rd_diff, rc_inc;
  logic               wr_last;
  logic [IDX_W-1:0]   wr_col, rd_col;
  logic               we, re;
  logic [ADDR_W-1:0]  waddr, raddr;
  logic [STORE_W-1:0] wdata, rdata;

  function automatic logic [ADDR_W-1:0] store_addr(logic bank, logic [IDX_W-1:0] col);
    return bank ? ADDR_W'(rpo_pkg::MAX_WIDTH) + ADDR_W'(col) : ADDR_W'(col);
  endfunction

  // mirror mode when the flip count is odd
  always_comb begin
    odd = 1'b0;
    for (int i = 0; i < rpo_pkg::NUM_SLOTS; i++) begin
      odd = odd ^ (rpo_pkg::slot_code(cfg.op_program, i) == rpo_pkg::OP_FLIP);
    end
  end

  // effective width and column arithmetic
  always_comb begin
    if (cfg.row_width == '0) w_eff = COL_W'(1);
    else if (32'(cfg.row_width) > rpo_pkg::MAX_WIDTH) w_eff = COL_W'(rpo_pkg::MAX_WIDTH);
    else w_eff = COL_W'(cfg.row_width);
  end

  assign wm1     = w_eff - COL_W'(1);
  assign wr_last = COL_W'(write_column) >= wm1;
  assign wr_col  = wr_last ? wm1[IDX_W-1:0] : write_column;
  assign rd_diff = wm1 - read_column;
  assign rd_col  = rd_diff[IDX_W-1:0];
  assign rc_inc  = read_column + COL_W'(1);

  assign acc_r      = !r_valid || result.ready;
  assign tail_ready = acc_r;
  assign fire       = tail_valid && acc_r;

  assign waddr = store_addr(write_bank, wr_col);
  assign raddr = store_addr(!write_bank, rd_col);
  assign wdata = {tail.over, tail.pix};

  // next state, store access and result select
  always_comb begin
    write_column_next = write_column;
    write_bank_next   = write_bank;
    stored_ready_next = stored_ready;
    read_column_next  = read_column;
    we           = 1'b0;
    re           = 1'b0;
    res_valid    = 1'b0;
    res_from_ram = 1'b0;
    res_last     = 1'b0;
    if (fire) begin
      if (!tail.drain && !odd) begin
        // direct pixel
        res_valid         = 1'b1;
        res_last          = wr_last;
        write_column_next = wr_last ? '0 : write_column + IDX_W'(1);
      end else begin
        // stored pixel read, drain or mirror pixel
        if (stored_ready) begin
          if (read_column >= w_eff) begin
            stored_ready_next = 1'b0;
          end else begin
            re               = 1'b1;
            res_valid        = 1'b1;
            res_from_ram     = 1'b1;
            res_last         = read_column == wm1;
            read_column_next = rc_inc;
            if (rc_inc >= w_eff) stored_ready_next = 1'b0;
          end
        end
        // mirror pixel goes into the write bank
        if (!tail.drain) begin
          we = 1'b1;
          if (wr_last) begin
            write_column_next = '0;
            write_bank_next   = !write_bank;
            stored_ready_next = 1'b1;
            read_column_next  = '0;
          end else begin
            write_column_next = write_column + IDX_W'(1);
          end
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      write_column <= '0;
      write_bank   <= 1'b0;
      stored_ready <= 1'b0;
      read_column  <= '0;
      r_valid      <= 1'b0;
    end else begin
      write_column <= write_column_next;
      write_bank   <= write_bank_next;
      stored_ready <= stored_ready_next;
      read_column  <= read_column_next;
      if (acc_r) r_valid <= fire && res_valid;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (acc_r) begin
      r_from_ram <= res_from_ram;
      r_last     <= res_last;
      r_over     <= tail.over;
      r_pix      <= tail.pix;
    end
  end

  rpo_ram #(
    .WIDTH (STORE_W),
    .DEPTH (2 * rpo_pkg::MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // outputs, store data held until the next read
  assign result.valid      = r_valid;
  assign result.out_red    = F'(r_from_ram ? rdata[2*C +: C] : r_pix.r);
  assign result.out_green  = F'(r_from_ram ? rdata[C +: C] : r_pix.g);
  assign result.out_blue   = F'(r_from_ram ? rdata[0 +: C] : r_pix.b);
  assign result.row_end    = r_last;
  assign result.over_range = r_from_ram ? rdata[3*C] : r_over;

  // checks
  `RPO_ASSERT_SAME(a_bank_split, clk, rst, we && re, (waddr >= ADDR_W'(rpo_pkg::MAX_WIDTH)) != (raddr >= ADDR_W'(rpo_pkg::MAX_WIDTH)), "store read and write hit the same bank")
  `RPO_ASSERT_NEXT(a_read_lands, clk, rst, re, r_valid && r_from_ram, "store read did not land in the result register")
  `RPO_ASSERT_SAME(a_rdata_hold, clk, rst, r_valid && !result.ready, !re, "store read while a result waits")
  `RPO_ASSERT_NEXT(a_row_closed, clk, rst, fire && we && wr_last, stored_ready && read_column == '0, "closed row not marked as stored")

endmodule

[rtl/rgb_point_ops_row_mirror.sv]
`timescale 1ns / 1ps

// channel     role    handshake      payload
// pixel       sink    valid/ready    operation, red, green, blue
// result      source  valid/ready    out_red, out_green, out_blue, row_end, over_range
// reg_write   sink    valid/ready    index, data (ready always high)
//
// one item per cycle while the result is not stalled; items pass the slot stages to the result register,
// one slot per pipeline stage, the divide by three of gray is a reciprocal multiply
// mirror mode delays each row by one row through a 2 x MAX_WIDTH line store
// synchronous reset clears control state; the line store is not cleared
// a stalled result holds its register, empty stages upstream keep accepting

module rgb_point_ops_row_mirror (
  input  logic          clk,
  input  logic          rst,
  rpo_pixel_if.sink     pixel,
  rpo_result_if.source  result,
  rpo_reg_if.sink       reg_write
);

  rpo_pkg::cfg_t   cfg;
  logic            tail_valid;
  logic            tail_ready;
  rpo_pkg::stage_t tail;

  assign reg_write.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.op_program <= rpo_pkg::OP_PROGRAM_RESET;
      cfg.color_max  <= rpo_pkg::COLOR_MAX_RESET;
      cfg.row_width  <= rpo_pkg::ROW_WIDTH_RESET;
    end else if (reg_write.valid) begin
      case (reg_write.index)
        rpo_pkg::REG_OP_PROGRAM: cfg.op_program <= reg_write.data;
        rpo_pkg::REG_COLOR_MAX:  cfg.color_max  <= reg_write.data[rpo_pkg::CMAX_W-1:0];
        rpo_pkg::REG_ROW_WIDTH:  cfg.row_width  <= reg_write.data[rpo_pkg::RWIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  rpo_slot_pipe u_slot_pipe (
    .clk        (clk),
    .rst        (rst),
    .pixel      (pixel),
    .cfg        (cfg),
    .tail_valid (tail_valid),
    .tail       (tail),
    .tail_ready (tail_ready)
  );

  rpo_mirror u_mirror (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .tail_valid (tail_valid),
    .tail       (tail),
    .tail_ready (tail_ready),
    .result     (result)
  );

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import rpo_pkg::*;

  localparam int  RESET_CYCLES  = 12;
  localparam int  SETTLE_CYCLES = 3 * (NUM_SLOTS + 1) + 4;
  localparam int  RANDOM_PIXELS = 680;
  localparam int  RUN_LIMIT_NS  = 2_000_000;
  // codes 9 to 15 do nothing
  localparam logic [3:0] SLOT_UNUSED = 4'hF;

  typedef struct packed {
    logic  op;
    comp_t r;
    comp_t g;
    comp_t b;
  } pixel_request_t;

  typedef struct packed {
    comp_t r;
    comp_t g;
    comp_t b;
    logic  over;
  } stored_pixel_t;

  typedef struct packed {
    comp_t r;
    comp_t g;
    comp_t b;
    logic  row_end;
    logic  over_range;
  } expected_pixel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rpo_pixel_if  pixel_bus ();
  rpo_result_if result_bus ();
  rpo_reg_if    reg_bus ();

  rgb_point_ops_row_mirror DUT (
    .clk       (clk),
    .rst       (rst),
    .pixel     (pixel_bus),
    .result    (result_bus),
    .reg_write (reg_bus)
  );

  always #5 clk = ~clk;

  pixel_request_t  pending_items[$];
  expected_pixel_t expected_pixels[$];
  int              mismatches = 0;
  int              idle_odds  = 0;
  int              send_hold  = 0;
  int              recv_hold  = 0;
  bit              pixel_taken = 1'b0;

  // generator copy of the programmed settings
  logic [PROG_W-1:0]   gen_prog;
  logic [CMAX_W-1:0]   gen_cmax;

  // mirror model state and its copy of the registers
  stored_pixel_t       line_mem [0:2*MAX_WIDTH-1];
  logic [COL_W-1:0]    wr_col   = '0;
  logic                wr_bank  = 1'b0;
  logic                row_held = 1'b0;
  logic [COL_W-1:0]    rd_col   = '0;
  logic [PROG_W-1:0]   prog_reg  = OP_PROGRAM_RESET;
  logic [CMAX_W-1:0]   cmax_reg  = COLOR_MAX_RESET;
  logic [RWIDTH_W-1:0] width_reg = ROW_WIDTH_RESET;

  function automatic bit has_odd_flips(input logic [PROG_W-1:0] prog);
    int i;
    bit odd;
    odd = 1'b0;
    for (i = 0; i < NUM_SLOTS; i++)
      if (prog[4*i +: 4] == OP_FLIP) odd = ~odd;
    return odd;
  endfunction

  function automatic int active_width();
    int w;
    w = int'(width_reg);
    if (w == 0) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  function automatic comp_t distance_to_max(input comp_t v);
    return (v >= cmax_reg) ? comp_t'(v - cmax_reg) : comp_t'(cmax_reg - v);
  endfunction

  // run the slot program over one pixel, out of range pixels pass unchanged
  function automatic stored_pixel_t transform_pixel(input comp_t r, input comp_t g,
                                                    input comp_t b);
    stored_pixel_t p;
    logic [3:0]    code;
    int            i;
    int            sum;
    p.r = r;
    p.g = g;
    p.b = b;
    p.over = (r > cmax_reg) || (g > cmax_reg) || (b > cmax_reg);
    for (i = 0; i < NUM_SLOTS; i++) begin
      code = prog_reg[4*i +: 4];
      if (!p.over) begin
        case (code)
          OP_NEG_R:  p.r = distance_to_max(p.r);
          OP_NEG_G:  p.g = distance_to_max(p.g);
          OP_NEG_B:  p.b = distance_to_max(p.b);
          OP_FLAT_R: p.r = '0;
          OP_FLAT_G: p.g = '0;
          OP_FLAT_B: p.b = '0;
          OP_GRAY: begin
            sum = int'(p.r) + int'(p.g) + int'(p.b);
            p.r = comp_t'(sum / 3);
            p.g = p.r;
            p.b = p.r;
          end
          default: ;
        endcase
      end
    end
    return p;
  endfunction

  // emit the next mirrored pixel of the held row, if any
  task automatic read_held_row();
    int              w;
    stored_pixel_t   px;
    expected_pixel_t res;
    w = active_width();
    if (!row_held) return;
    if (rd_col >= w) begin
      row_held = 1'b0;
      return;
    end
    px = line_mem[(wr_bank ? 0 : MAX_WIDTH) + (w - 1 - int'(rd_col))];
    res.r = px.r;
    res.g = px.g;
    res.b = px.b;
    res.row_end = (rd_col == w - 1);
    res.over_range = px.over;
    expected_pixels.push_back(res);
    rd_col = rd_col + 1'b1;
    if (rd_col >= w) row_held = 1'b0;
  endtask

  task automatic predict_item(input logic op, input comp_t r, input comp_t g,
                              input comp_t b);
    stored_pixel_t   px;
    expected_pixel_t res;
    logic            row_done;
    int              w;
    if (op == ITEM_DRAIN) begin
      read_held_row();
      return;
    end
    px = transform_pixel(r, g, b);
    w = active_width();
    row_done = (wr_col >= w - 1);
    if (!has_odd_flips(prog_reg)) begin
      res.r = px.r;
      res.g = px.g;
      res.b = px.b;
      res.row_end = row_done;
      res.over_range = px.over;
      expected_pixels.push_back(res);
      wr_col = row_done ? '0 : wr_col + 1'b1;
    end else begin
      read_held_row();
      line_mem[(wr_bank ? MAX_WIDTH : 0) + (row_done ? w - 1 : int'(wr_col))] = px;
      if (row_done) begin
        wr_col = '0;
        wr_bank = ~wr_bank;
        row_held = 1'b1;
        rd_col = '0;
      end else begin
        wr_col = wr_col + 1'b1;
      end
    end
  endtask

  // result check, input prediction and register tracking
  always @(posedge clk) begin : observer
    expected_pixel_t want;
    pixel_taken <= pixel_bus.valid && pixel_bus.ready;
    if (!rst) begin
      if (result_bus.valid && result_bus.ready) begin
        if (expected_pixels.size() == 0) begin
          $error("result with no pending expectation: %0h %0h %0h",
                 result_bus.out_red, result_bus.out_green, result_bus.out_blue);
          mismatches++;
        end else begin
          want = expected_pixels.pop_front();
          if (result_bus.out_red !== want.r) begin
            $error("out_red: expected %0h, actual %0h", want.r, result_bus.out_red);
            mismatches++;
          end
          if (result_bus.out_green !== want.g) begin
            $error("out_green: expected %0h, actual %0h", want.g, result_bus.out_green);
            mismatches++;
          end
          if (result_bus.out_blue !== want.b) begin
            $error("out_blue: expected %0h, actual %0h", want.b, result_bus.out_blue);
            mismatches++;
          end
          if (result_bus.row_end !== want.row_end) begin
            $error("row_end: expected %0b, actual %0b", want.row_end, result_bus.row_end);
            mismatches++;
          end
          if (result_bus.over_range !== want.over_range) begin
            $error("over_range: expected %0b, actual %0b", want.over_range,
                   result_bus.over_range);
            mismatches++;
          end
        end
      end
      if (pixel_bus.valid && pixel_bus.ready)
        predict_item(pixel_bus.operation, pixel_bus.red, pixel_bus.green, pixel_bus.blue);
      if (reg_bus.valid && reg_bus.ready) begin
        case (reg_bus.index)
          REG_OP_PROGRAM: prog_reg  = reg_bus.data;
          REG_COLOR_MAX:  cmax_reg  = reg_bus.data[CMAX_W-1:0];
          REG_ROW_WIDTH:  width_reg = reg_bus.data[RWIDTH_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // pixel request driver with random gaps
  always @(negedge clk) begin : pixel_driver
    pixel_request_t req;
    if (rst) begin
      pixel_bus.valid <= 1'b0;
    end else if (!pixel_bus.valid || pixel_taken) begin
      if (send_hold > 0) begin
        pixel_bus.valid <= 1'b0;
        send_hold <= send_hold - 1;
      end else if (pending_items.size() != 0) begin
        req = pending_items.pop_front();
        pixel_bus.valid     <= 1'b1;
        pixel_bus.operation <= req.op;
        pixel_bus.red       <= req.r;
        pixel_bus.green     <= req.g;
        pixel_bus.blue      <= req.b;
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
          send_hold <= $urandom_range(1, 3);
      end else begin
        pixel_bus.valid <= 1'b0;
      end
    end
  end

  // result ready with random stalls
  always @(negedge clk) begin : result_sink
    if (rst) begin
      result_bus.ready <= 1'b0;
    end else if (recv_hold > 0) begin
      result_bus.ready <= 1'b0;
      recv_hold <= recv_hold - 1;
    end else begin
      result_bus.ready <= 1'b1;
      if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
        recv_hold <= $urandom_range(1, 3);
    end
  end

  task automatic push_pixel(input comp_t r, input comp_t g, input comp_t b);
    pixel_request_t req;
    req.op = ITEM_PIXEL;
    req.r = r;
    req.g = g;
    req.b = b;
    pending_items.push_back(req);
  endtask

  // drain request, color fields carry noise
  task automatic push_drain();
    pixel_request_t req;
    req.op = ITEM_DRAIN;
    req.r = comp_t'($urandom);
    req.g = comp_t'($urandom);
    req.b = comp_t'($urandom);
    pending_items.push_back(req);
  endtask

  function automatic comp_t rand_comp(input logic [CMAX_W-1:0] m);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return comp_t'(m);
      2:       return comp_t'($urandom);
      default: return comp_t'($urandom_range(0, m));
    endcase
  endfunction

  task automatic push_random_pixel();
    push_pixel(rand_comp(gen_cmax), rand_comp(gen_cmax), rand_comp(gen_cmax));
  endtask

  // wait until every request is taken and every result is back
  task automatic settle();
    while (pending_items.size() != 0 || pixel_bus.valid) @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [PROG_W-1:0] val);
    @(negedge clk);
    reg_bus.valid <= 1'b1;
    reg_bus.index <= idx;
    reg_bus.data  <= val;
    @(posedge clk);
    while (!reg_bus.ready) @(posedge clk);
    @(negedge clk);
    reg_bus.valid <= 1'b0;
  endtask

  task automatic configure(input logic [PROG_W-1:0] prog, input logic [CMAX_W-1:0] cmax,
                           input logic [RWIDTH_W-1:0] width);
    settle();
    write_reg(REG_OP_PROGRAM, prog);
    write_reg(REG_COLOR_MAX, PROG_W'(cmax));
    write_reg(REG_ROW_WIDTH, PROG_W'(width));
    gen_prog  = prog;
    gen_cmax  = cmax;
    @(posedge clk);
  endtask

  function automatic logic [PROG_W-1:0] random_program();
    logic [PROG_W-1:0] prog;
    int                i;
    case ($urandom_range(0, 9))
      0: prog = '0;
      1: prog = '1;
      default: begin
        for (i = 0; i < NUM_SLOTS; i++)
          prog[4*i +: 4] = ($urandom_range(0, 3) == 0) ? 4'(OP_FLIP) :
                                                        4'($urandom_range(0, 15));
      end
    endcase
    return prog;
  endfunction

  function automatic logic [CMAX_W-1:0] random_max();
    case ($urandom_range(0, 4))
      0:       return CMAX_W'(1);
      1:       return '1;
      2:       return COLOR_MAX_RESET;
      3:       return CMAX_W'($urandom_range(1, 1023));
      default: return CMAX_W'($urandom_range(1, 65535));
    endcase
  endfunction

  initial begin : stimulus
    int w;
    int wcap;
    int rows;
    int held_w;
    int random_pixels;
    int n;
    bit mirror;

    pixel_bus.valid     = 1'b0;
    pixel_bus.operation = ITEM_PIXEL;
    pixel_bus.red       = '0;
    pixel_bus.green     = '0;
    pixel_bus.blue      = '0;
    result_bus.ready    = 1'b0;
    reg_bus.valid       = 1'b0;
    reg_bus.index       = REG_OP_PROGRAM;
    reg_bus.data        = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);
    idle_odds = 4;

    // every negate and the first flatten on the component extremes
    configure({OP_NONE, OP_NONE, OP_NONE, OP_NONE, OP_FLAT_R, OP_NEG_B, OP_NEG_G,
               OP_NEG_R}, '1, 2);
    push_pixel('0, '0, '0);
    push_pixel('1, '1, '1);

    // remaining flattens, gray and an unused code, smallest max, over range pixels
    configure({OP_NONE, OP_NONE, OP_NONE, OP_NONE, SLOT_UNUSED, OP_GRAY, OP_FLAT_B,
               OP_FLAT_G}, 1, 3);
    push_pixel(1, 1, 1);
    push_pixel(1, 0, 2);
    push_pixel('1, '0, '0);

    // mirror mode: first row stored, drain and pixels read it back
    configure({OP_NONE, OP_NONE, OP_NONE, OP_NONE, OP_NONE, OP_NONE, OP_NEG_G, OP_FLIP},
              COLOR_MAX_RESET, 3);
    push_pixel(10, 20, 30);
    push_pixel(40, 50, 60);
    push_pixel(70, 80, 90);
    push_drain();
    repeat (3) push_random_pixel();

    // back to direct mode with a row still held, drains empty it
    configure({OP_NONE, OP_NONE, OP_NONE, OP_NONE, OP_NONE, OP_NONE, OP_NONE, OP_NEG_R},
              COLOR_MAX_RESET, 3);
    push_random_pixel();
    push_drain();
    push_drain();
    push_random_pixel();
    push_drain();
    push_drain();
    push_random_pixel();

    // width shrunk while a held row is half read
    configure({OP_NONE, OP_NONE, OP_NONE, OP_NONE, OP_NONE, OP_NONE, OP_NONE, OP_FLIP},
              COLOR_MAX_RESET, 3);
    repeat (5) push_random_pixel();
    configure(gen_prog, COLOR_MAX_RESET, 1);
    push_random_pixel();
    push_drain();

    // widest row cut short, then a zero width
    configure('1, COLOR_MAX_RESET, '1);
    repeat (3) push_random_pixel();
    configure('0, COLOR_MAX_RESET, '0);
    repeat (2) push_random_pixel();

    // random phases of whole rows; a held row limits the next width
    held_w = 0;
    random_pixels = 0;
    while (random_pixels < RANDOM_PIXELS) begin
      if (random_pixels > RANDOM_PIXELS * 17 / 20) begin
        idle_odds = 0;
      end else begin
        case ($urandom_range(0, 3))
          0:       idle_odds = 0;
          1:       idle_odds = 3;
          2:       idle_odds = 6;
          default: idle_odds = 10;
        endcase
      end
      wcap = ($urandom_range(0, 7) == 0) ? 48 : 8;
      if (held_w != 0 && held_w < wcap) wcap = held_w;
      w = $urandom_range(1, wcap);
      configure(random_program(), random_max(), RWIDTH_W'(w));
      mirror = has_odd_flips(gen_prog);
      rows = $urandom_range(1, (w <= 4) ? 6 : 3);
      for (n = 0; n < rows * w; n++) begin
        if ($urandom_range(0, 5) == 0) push_drain();
        push_random_pixel();
      end
      random_pixels += rows * w;
      if (mirror) held_w = w;
      if (held_w != 0) begin
        if ($urandom_range(0, 2) != 0) begin
          repeat (w) push_drain();
          held_w = 0;
        end else begin
          repeat ($urandom_range(0, w)) push_drain();
        end
      end
    end

    settle();
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(RUN_LIMIT_NS);
    $display("Mismatches found");
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/rpo_pkg.sv
rtl/rpo_pixel_if.sv
rtl/rpo_result_if.sv
rtl/rpo_reg_if.sv
rtl/rpo_ram.sv
rtl/rpo_slot_pipe.sv
rtl/rpo_mirror.sv
rtl/rgb_point_ops_row_mirror.sv
tb/testbench.sv
